// ===== design/prf_pkg.sv =====
// ---------------------------------------------------------------------------
// prf_pkg
// Shared constants and types for the packet replay filter: window size,
// reciprocal for the block-base divide, stream widths and status codes.
// ---------------------------------------------------------------------------
package prf_pkg;

   localparam int WINDOW   = 10;
   localparam int SEQ_W    = 32;
   localparam int NONCE_W  = 32;
   localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   // floor(seq / WINDOW) = (seq * RECIP) >> RECIP_SHIFT for every 32-bit seq
   localparam int           RECIP_SHIFT = SEQ_W + IDX_W;
   localparam logic [63:0]  RECIP_FULL  = ((64'd1 << RECIP_SHIFT) / WINDOW) + 64'd1;
   localparam logic [SEQ_W:0] RECIP     = RECIP_FULL[SEQ_W:0];
   localparam int           PROD_W      = SEQ_W + SEQ_W + 1;

   localparam int REQ_W    = SEQ_W + NONCE_W;
   localparam int STATUS_W = 3;
   localparam int RSP_W    = 8;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_SEQ        = 3'd1,
      ST_OLD_BLOCK  = 3'd2,
      ST_OUT_WINDOW = 3'd3,
      ST_REPLAY     = 3'd4
   } status_type;

endpackage

// ===== design/packet_replay_filter_unit.sv =====
// ---------------------------------------------------------------------------
// packet_replay_filter_unit
// Anti-replay window check: one packet (sequence number and nonce) in, one
// accept flag and status code out.
// ---------------------------------------------------------------------------
// One packet per clock is taken and each result goes through the stages below once its
// beat is accepted: the first stage registers the packet together with the
// quotient seq / WINDOW (one multiply by a constant reciprocal), the second
// forms the block base, runs the sequence, block and nonce checks against the
// stored last sequence, block base and used-nonce mask, updates that state
// and registers the result. The state is updated as the packet leaves the
// first stage, so the packet right behind it already sees the new state.
// Back-pressure on rsp_tready stalls both stages; with rsp_tready held high
// the throughput is one packet per cycle.
module packet_replay_filter_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [prf_pkg::REQ_W-1:0]   req_tdata,   // seq_num[31:0], nonce_value[63:32]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [prf_pkg::RSP_W-1:0]   rsp_tdata    // accepted[0], status[3:1], zero[7:4]
);
   import prf_pkg::*;

   // stage 1: registered packet and quotient
   logic                 s1_valid_ff, s1_valid_in;
   logic [SEQ_W-1:0]     s1_seq_ff;
   logic [NONCE_W-1:0]   s1_nonce_ff;
   logic [SEQ_W-1:0]     s1_quot_ff;

   // filter state
   logic [SEQ_W-1:0]     last_seq_ff, last_seq_in;
   logic [SEQ_W-1:0]     block_base_ff, block_base_in;
   logic [WINDOW-1:0]    used_mask_ff, used_mask_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;

   logic                 req_fire;
   logic                 s1_adv;
   logic                 s1_fire;
   logic [PROD_W-1:0]    prod;
   logic [PROD_W-1:0]    prod_shr;
   logic [SEQ_W-1:0]     req_seq;
   logic [NONCE_W-1:0]   req_nonce;

   logic [SEQ_W-1:0]     base;
   logic                 seq_ok;
   logic                 newer_blk;
   logic                 older_blk;
   logic [NONCE_W-1:0]   diff;
   logic                 in_win;
   logic [IDX_W-1:0]     idx;
   logic [WINDOW-1:0]    bit_sel;
   logic [WINDOW-1:0]    mask_eff;
   logic                 hit;
   status_type           status;

   assign req_seq   = req_tdata[SEQ_W-1:0];
   assign req_nonce = req_tdata[REQ_W-1:SEQ_W];

   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_fire    = s1_valid_ff && s1_adv;

   assign prod     = PROD_W'(req_seq) * PROD_W'(RECIP);
   assign prod_shr = prod >> RECIP_SHIFT;

   // checks on the packet in stage 1
   always_comb begin
      base      = s1_quot_ff * SEQ_W'(WINDOW);
      seq_ok    = s1_seq_ff > last_seq_ff;
      newer_blk = base > block_base_ff;
      older_blk = base < block_base_ff;
      diff      = s1_nonce_ff - base;
      in_win    = (s1_nonce_ff >= base) && (diff < NONCE_W'(WINDOW));
      idx       = diff[IDX_W-1:0];
      bit_sel   = {{(WINDOW-1){1'b0}}, 1'b1} << idx;
      mask_eff  = newer_blk ? '0 : used_mask_ff;
      hit       = (mask_eff & bit_sel) != '0;

      if (!seq_ok) begin
         status = ST_SEQ;
      end else if (older_blk) begin
         status = ST_OLD_BLOCK;
      end else if (!in_win) begin
         status = ST_OUT_WINDOW;
      end else if (hit) begin
         status = ST_REPLAY;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      last_seq_in   = last_seq_ff;
      block_base_in = block_base_ff;
      used_mask_in  = used_mask_ff;
      if (s1_fire && seq_ok) begin
         last_seq_in = s1_seq_ff;
         if (newer_blk) begin
            block_base_in = base;
         end
         if (!older_blk) begin
            // a newer block clears the mask even if the nonce is rejected
            used_mask_in = mask_eff | (in_win ? bit_sel : '0);
         end
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (req_tready) begin
         s1_valid_in = req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_seq_ff   <= '0;
         block_base_ff <= '0;
         used_mask_ff  <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_seq_ff   <= last_seq_in;
         block_base_ff <= block_base_in;
         used_mask_ff  <= used_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_seq_ff   <= req_seq;
         s1_nonce_ff <= req_nonce;
         s1_quot_ff  <= prod_shr[SEQ_W-1:0];
      end
      if (s1_fire) begin
         rsp_status_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-STATUS_W-1){1'b0}}, rsp_status_ff, (rsp_status_ff == ST_OK)};

endmodule

// ===== design/prf_checker.sv =====
// ---------------------------------------------------------------------------
// prf_checker
// Port-level checks for the packet replay filter, bound to the top level.
// ---------------------------------------------------------------------------
module prf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [prf_pkg::REQ_W-1:0]   req_tdata,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [prf_pkg::RSP_W-1:0]   rsp_tdata
);
   import prf_pkg::*;

   // a stalled packet beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("packet beat changed while stalled");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // accept flag agrees with status
   a_accept_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[3:1] == ST_OK)))
      else $error("accept flag disagrees with status");

   // status is a known code and padding is zero
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:1] == ST_OK || rsp_tdata[3:1] == ST_SEQ ||
                      rsp_tdata[3:1] == ST_OLD_BLOCK || rsp_tdata[3:1] == ST_OUT_WINDOW ||
                      rsp_tdata[3:1] == ST_REPLAY) && rsp_tdata[7:4] == 4'd0)
      else $error("bad status code or padding");

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind packet_replay_filter_unit prf_checker u_prf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb_packet_replay_filter_unit.sv =====
// ---------------------------------------------------------------------------
// tb_packet_replay_filter_unit
// Self-checking bench for the packet replay filter. A short table of probe
// packets walks the sequence, block and nonce checks. Random packets follow
// in eight segments whose bases climb through the 32-bit sequence space, and
// a closing table covers the top of that space. Every verdict beat is
// compared with the row's typed status or else a local model of the filter
// state. Both stream sides idle in random bursts.
// ---------------------------------------------------------------------------
module tb_packet_replay_filter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import prf_pkg::*;

   typedef struct {
      logic [31:0] seq;
      logic [31:0] nonce;
      bit          typed;
      status_type  status;
   } probe_row_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;   // seq_num[31:0], nonce_value[63:32]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;         // accepted[0], status[3:1], zero[7:4]

   // filter state as the bench sees it
   logic [31:0]          seen_seq;
   logic [31:0]          seen_base;
   logic [WINDOW-1:0]    nonce_used;

   status_type           verdict_queue[$];
   logic [31:0]          seq_cursor;
   bit                   gaps_on = 1'b1;
   int                   mismatch_count = 0;
   int                   verdict_total = 0;
   int                   status_tally[8];

   // old-block status cannot occur: the base never falls while seq rises
   probe_row_type opening_rows[19] = '{
      '{32'd0,  32'd0,          1'b1, ST_SEQ},
      '{32'd0,  32'hFFFF_FFFF,  1'b1, ST_SEQ},
      '{32'd5,  32'd0,          1'b1, ST_OK},
      '{32'd6,  32'd0,          1'b1, ST_REPLAY},
      '{32'd7,  32'd9,          1'b1, ST_OK},
      '{32'd8,  32'd10,         1'b1, ST_OUT_WINDOW},
      '{32'd8,  32'd1,          1'b1, ST_SEQ},
      '{32'd3,  32'd1,          1'b1, ST_SEQ},
      '{32'd9,  32'd1,          1'b1, ST_OK},
      '{32'd10, 32'd1,          1'b1, ST_OUT_WINDOW},
      '{32'd11, 32'd10,         1'b1, ST_OK},
      '{32'd12, 32'd10,         1'b1, ST_REPLAY},
      '{32'd25, 32'd19,         1'b1, ST_OUT_WINDOW},
      '{32'd26, 32'd20,         1'b1, ST_OK},
      '{32'd27, 32'd29,         1'b0, ST_OK},
      '{32'd28, 32'd30,         1'b1, ST_OUT_WINDOW},
      '{32'd29, 32'hFFFF_FFFF,  1'b1, ST_OUT_WINDOW},
      '{32'd30, 32'd30,         1'b0, ST_OK},
      '{32'd31, 32'd30,         1'b0, ST_OK}
   };

   probe_row_type closing_rows[7] = '{
      '{32'hFFFF_FFF0, 32'hFFFF_FFF0, 1'b1, ST_OK},
      '{32'hFFFF_FFF1, 32'hFFFF_FFEF, 1'b1, ST_OUT_WINDOW},
      '{32'hFFFF_FFF9, 32'hFFFF_FFF9, 1'b1, ST_OK},
      '{32'hFFFF_FFFA, 32'd0,         1'b1, ST_OUT_WINDOW},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_SEQ},
      '{32'd0,         32'd0,         1'b1, ST_SEQ}
   };

   packet_replay_filter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [31:0] block_start(input logic [31:0] seq);
      return (seq / 32'(WINDOW)) * 32'(WINDOW);
   endfunction

   // advances the filter state for one packet and returns its status
   function automatic status_type screen_packet(input logic [31:0] seq,
                                                input logic [31:0] nonce);
      logic [31:0] base;
      logic [31:0] offset;
      if (seq <= seen_seq)
         return ST_SEQ;
      seen_seq = seq;
      base = block_start(seq);
      if (base > seen_base) begin
         seen_base  = base;
         nonce_used = '0;
      end else if (base < seen_base) begin
         return ST_OLD_BLOCK;
      end
      offset = nonce - base;
      if (nonce < base || offset >= 32'(WINDOW))
         return ST_OUT_WINDOW;
      if (nonce_used[offset])
         return ST_REPLAY;
      nonce_used[offset] = 1'b1;
      return ST_OK;
   endfunction

   task automatic drive_packet(input logic [31:0] seq, input logic [31:0] nonce,
                               input bit typed, input status_type typed_status);
      status_type verdict;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {nonce, seq};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      verdict = screen_packet(seq, nonce);
      verdict_queue.push_back(typed ? typed_status : verdict);
   endtask

   // well-formed climbing sequences mostly, with stale numbers and stray nonces
   task automatic pick_packet(output logic [31:0] seq, output logic [31:0] nonce);
      int          roll;
      logic [31:0] base;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         seq = seq_cursor - $urandom_range(0, (seq_cursor < 50) ? seq_cursor : 50);
      else if (roll < 25)
         seq = seq_cursor + $urandom_range(10, 40);
      else if (roll < 30)
         seq = seq_cursor + $urandom_range(1000, 1 << 20);
      else
         seq = seq_cursor + $urandom_range(1, 3);
      if (seq > seq_cursor)
         seq_cursor = seq;
      base = block_start(seq);
      roll = $urandom_range(0, 99);
      if (roll < 70)
         nonce = base + $urandom_range(0, WINDOW - 1);
      else if (roll < 80)
         nonce = base - $urandom_range(1, 5);
      else if (roll < 90)
         nonce = base + WINDOW + $urandom_range(0, 5);
      else
         nonce = $urandom;
   endtask

   initial begin
      forever begin
         if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : verdict_check
      status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_queue.size() == 0) begin
            $error("verdict beat with nothing expected: tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = verdict_queue.pop_front();
            verdict_total++;
            status_tally[rsp_tdata[3:1]]++;
            if (rsp_tdata[0] !== (want == ST_OK)) begin
               $error("accepted mismatch: expected %0d, actual %0d",
                      (want == ST_OK), rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[3:1] !== want) begin
               $error("status mismatch: expected %0d, actual %0d", want, rsp_tdata[3:1]);
               mismatch_count++;
            end
            if (rsp_tdata[7:4] !== 4'd0) begin
               $error("pad mismatch: expected 0, actual %0d", rsp_tdata[7:4]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [31:0] seq;
      logic [31:0] nonce;
      logic [31:0] seg_start;
      seen_seq   = '0;
      seen_base  = '0;
      nonce_used = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_rows[i])
         drive_packet(opening_rows[i].seq, opening_rows[i].nonce,
                      opening_rows[i].typed, opening_rows[i].status);

      // segment bases spread the top byte so every sequence bit toggles
      seq_cursor = seen_seq;
      for (int seg = 0; seg < 8; seg++) begin
         seg_start = seg * 32'h1F00_0000 + $urandom_range(0, 32'h00FF_FFFF);
         if (seg_start > seq_cursor)
            seq_cursor = seg_start;
         if (seg == 7)
            gaps_on = 1'b0;
         for (int n = 0; n < 78; n++) begin
            pick_packet(seq, nonce);
            drive_packet(seq, nonce, 1'b0, ST_OK);
         end
      end

      foreach (closing_rows[i])
         drive_packet(closing_rows[i].seq, closing_rows[i].nonce,
                      closing_rows[i].typed, closing_rows[i].status);
      req_tvalid <= 1'b0;

      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("checked %0d verdict beats across the full 32-bit sequence range",
               verdict_total);
      $display("  ok %0d, stale seq %0d, outside window %0d, replay %0d",
               status_tally[ST_OK], status_tally[ST_SEQ],
               status_tally[ST_OUT_WINDOW], status_tally[ST_REPLAY]);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
design/prf_pkg.sv
design/packet_replay_filter_unit.sv
design/prf_checker.sv
dv/tb_packet_replay_filter_unit.sv
